/* hw/rtl/sas_pkg.sv */
// Shared constants, tables and types for the stick azimuth pipeline.
`default_nettype none
package sas_pkg;
    localparam int STEPS = 28;
    localparam int DW = 34;
    localparam logic [31:0] PHASE_C = 32'd3499854211;
    localparam logic signed [DW-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [DW-1:0] Q30_ONE = 34'sd1073741824;
    localparam logic [15:0] K_RESET = 16'd16014;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW:0]   z;
    } rot_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
                5'd20: r = 32'd652;       5'd21: r = 32'd326;
                5'd22: r = 32'd163;       5'd23: r = 32'd81;
                5'd24: r = 32'd41;        5'd25: r = 32'd20;
                5'd26: r = 32'd10;        5'd27: r = 32'd5;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/sas_cell.sv */
// One CORDIC cell: a single rotation or vectoring step, registered.
`default_nettype none
module sas_cell
    import sas_pkg::*;
#(
    parameter int IDX = 0,
    parameter bit VEC = 1'b0
)(
    input  wire logic clk,
    input  wire logic en,
    input  wire rot_t d,
    output rot_t      q
);
    rot_t q_reg;
    rot_t q_next;
    logic dir;
    logic signed [DW:0] a;

    // Pick direction and advance one step
    always_comb
    begin
        a = $signed({3'b000, atan_turn(5'(IDX))});
        dir = VEC ? (d.y > 0) : (d.z >= 0);
        q_next = d;
        if (VEC)
        begin
            if (dir)
            begin
                q_next.x = d.x + (d.y >>> IDX);
                q_next.y = d.y - (d.x >>> IDX);
                q_next.z = d.z + a;
            end
            else
            begin
                q_next.x = d.x - (d.y >>> IDX);
                q_next.y = d.y + (d.x >>> IDX);
                q_next.z = d.z - a;
            end
        end
        else if (dir)
        begin
            q_next.x = d.x - (d.y >>> IDX);
            q_next.y = d.y + (d.x >>> IDX);
            q_next.z = d.z - a;
        end
        else
        begin
            q_next.x = d.x + (d.y >>> IDX);
            q_next.y = d.y - (d.x >>> IDX);
            q_next.z = d.z + a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

/* hw/rtl/sas_sincos.sv */
// Sine/cosine chain: phase in, registered Q30 sine and cosine out.
`default_nettype none
module sas_sincos
    import sas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] phase,
    output logic signed [DW-1:0] sin_q,
    output logic signed [DW-1:0] cos_q
);
    rot_t chain [0:STEPS];
    logic [STEPS-1:0] flip_reg;
    logic [STEPS-1:0] zero_reg;
    logic [31:0] p;
    logic flip;

    // Fold to the right half turn
    always_comb
    begin
        flip = ((phase + 32'h4000_0000) & 32'h8000_0000) != 32'd0;
        p = flip ? (phase - 32'h8000_0000) : phase;
        chain[0].x = GAIN_INV;
        chain[0].y = '0;
        chain[0].z = (DW+1)'($signed(p));
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        sas_cell #(.IDX(i), .VEC(1'b0)) u_cell (
            .clk(clk), .en(en), .d(chain[i]), .q(chain[i+1])
        );
    end

    // Carry flags alongside the chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= {flip_reg[STEPS-2:0], flip};
            zero_reg <= {zero_reg[STEPS-2:0], phase == 32'd0};
        end
    end

    // Final sign and exact zero case
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[STEPS-1])
            begin
                sin_q <= '0;
                cos_q <= Q30_ONE;
            end
            else if (flip_reg[STEPS-1])
            begin
                sin_q <= -chain[STEPS].y;
                cos_q <= -chain[STEPS].x;
            end
            else
            begin
                sin_q <= chain[STEPS].y;
                cos_q <= chain[STEPS].x;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/sas_atan.sv */
// Arctangent chain: vectoring CORDIC over (p, q), angle in 2^-32 turn.
`default_nettype none
module sas_atan
    import sas_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic signed [DW-1:0] p_in,
    input  wire logic signed [DW-1:0] q_in,
    output logic [31:0] angle
);
    rot_t chain [0:STEPS];
    logic [STEPS-1:0] qz_reg;
    logic [STEPS-1:0] pn_reg;

    // Pre-rotate by a half turn when p is negative
    always_comb
    begin
        if (p_in < 0)
        begin
            chain[0].x = -p_in;
            chain[0].y = -q_in;
            chain[0].z = (DW+1)'(64'sd2147483648);
        end
        else
        begin
            chain[0].x = p_in;
            chain[0].y = q_in;
            chain[0].z = '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        sas_cell #(.IDX(i), .VEC(1'b1)) u_cell (
            .clk(clk), .en(en), .d(chain[i]), .q(chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qz_reg <= {qz_reg[STEPS-2:0], q_in == 0};
            pn_reg <= {pn_reg[STEPS-2:0], p_in < 0};
        end
    end

    // Axis case bypasses the chain
    always_comb
    begin
        if (qz_reg[STEPS-1])
        begin
            angle = pn_reg[STEPS-1] ? 32'h8000_0000 : 32'd0;
        end
        else
        begin
            angle = chain[STEPS].z[31:0];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/stick_angle_on_sphere.sv */
// Stick azimuth on a sphere: phase scaling, sin/cos chains, products, atan chain.
// Registers from accepted item to valid result: 3 scale, 29 sin/cos, 2 product,
// 28 atan, 1 rounding. Throughput: one item per cycle while the output is not stalled.
// The pipeline advances whenever the result stage is empty or being taken.
// Reset clears the valid pipe and loads the tilt register with 16014.
`default_nettype none
module stick_angle_on_sphere
    import sas_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic signed [COORD_BITS-1:0] stick_x,
    input  wire logic signed [COORD_BITS-1:0] stick_y,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic [ANGLE_BITS-1:0] azimuth
);
    localparam int LAT = 3 + (STEPS + 1) + 2 + STEPS + 1;
    localparam int MW = COORD_BITS + 16;

    logic [15:0] k_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    logic [MW-1:0] mx_reg, my_reg;
    logic nx_reg, ny_reg, nx2_reg, ny2_reg;
    logic [MW+31:0] hx_reg, lx_reg, hy_reg, ly_reg;
    logic [31:0] phx_reg, phy_reg;
    logic signed [DW-1:0] sa, ca, sb, cb;
    logic signed [2*DW-1:0] pp_reg, qq_reg;
    logic signed [DW-1:0] p2_reg, q2_reg;
    logic [31:0] ang;
    logic [ANGLE_BITS-1:0] az_reg;
    logic [COORD_BITS-1:0] ax, ay;
    logic [MW+31:0] sx, sy;

    assign en = !out_valid || !out_stall;
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];
    assign azimuth = az_reg;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_we)
        begin
            k_reg <= cfg_wdata;
        end
    end

    // Advance the valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        ax = stick_x[COORD_BITS-1] ? (COORD_BITS)'(-stick_x) : stick_x;
        ay = stick_y[COORD_BITS-1] ? (COORD_BITS)'(-stick_y) : stick_y;
        sx = hx_reg + (lx_reg >> 16) + (MW+32)'(32'h8000);
        sy = hy_reg + (ly_reg >> 16) + (MW+32)'(32'h8000);
    end

    // Scale magnitudes to phase, three stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= MW'(ax) * MW'(k_reg);
            my_reg  <= MW'(ay) * MW'(k_reg);
            nx_reg  <= stick_x[COORD_BITS-1];
            ny_reg  <= stick_y[COORD_BITS-1];
            hx_reg  <= (MW+32)'(mx_reg) * (MW+32)'(PHASE_C[31:16]);
            lx_reg  <= (MW+32)'(mx_reg) * (MW+32)'(PHASE_C[15:0]);
            hy_reg  <= (MW+32)'(my_reg) * (MW+32)'(PHASE_C[31:16]);
            ly_reg  <= (MW+32)'(my_reg) * (MW+32)'(PHASE_C[15:0]);
            nx2_reg <= nx_reg;
            ny2_reg <= ny_reg;
            phx_reg <= nx2_reg ? -sx[47:16] : sx[47:16];
            phy_reg <= ny2_reg ? -sy[47:16] : sy[47:16];
        end
    end

    sas_sincos u_sc_a (.clk(clk), .en(en), .phase(phx_reg), .sin_q(sa), .cos_q(ca));
    sas_sincos u_sc_b (.clk(clk), .en(en), .phase(phy_reg), .sin_q(sb), .cos_q(cb));

    // Form the two cross products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= (2*DW)'(sa) * (2*DW)'(cb);
            qq_reg <= (2*DW)'(ca) * (2*DW)'(sb);
            p2_reg <= DW'(pp_reg >>> 30);
            q2_reg <= DW'(qq_reg >>> 30);
        end
    end

    sas_atan u_atan (.clk(clk), .en(en), .p_in(p2_reg), .q_in(q2_reg), .angle(ang));

    // Round to the output width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg <= ANGLE_BITS'((33'(ang) + (33'd1 << (31 - ANGLE_BITS)))
                      >> (32 - ANGLE_BITS));
        end
    end
endmodule
`default_nettype wire

/* tb/tb_stick_angle_on_sphere.sv */
// Testbench for the stick azimuth pipeline: random-stall driver, predictor and scoreboard.
`timescale 1ns / 100ps

module tb_stick_angle_on_sphere;
    import sas_pkg::*;

    localparam int  LATENCY_WAIT = 80;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  PHASE_ITEMS  = 105;
    localparam logic [15:0] FULL_DEFL = 16'd25600;

    // Predict the azimuth of each stick item and check results in order
    class azimuth_scoreboard;
        logic [15:0] tilt_k;
        logic [15:0] expected_az[$];
        longint      turn_tab[28];
        int          mismatches;
        int          checked;

        function new();
            tilt_k = K_RESET;
            mismatches = 0;
            checked = 0;
            turn_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                         81, 41, 20, 10, 5};
        endfunction

        // Scale a coordinate by K into a phase in 2^-32 turn
        function logic [31:0] tilt_phase(logic [15:0] coord);
            logic              neg;
            longint unsigned   mag, m, hi, lo, sum;
            logic [31:0]       ph;
            neg = coord[15];
            mag = neg ? (64'd65536 - coord) : coord;
            m   = mag * tilt_k;
            hi  = m * (PHASE_C >> 16);
            lo  = m * (PHASE_C & 32'hFFFF);
            sum = (hi + (lo >> 16) + 64'd32768) >> 16;
            ph  = sum[31:0];
            return neg ? (32'd0 - ph) : ph;
        endfunction

        // Rotation-mode CORDIC with half-turn folding
        function void sine_cosine(input logic [31:0] p, output longint s, output longint c);
            logic   flip;
            longint x, y, z, dx, dy;
            flip = 1'b0;
            if (p == 32'd0)
            begin
                s = 0;
                c = Q30_ONE;
                return;
            end
            if (((p + 32'h40000000) & 32'h80000000) != 0)
            begin
                flip = 1'b1;
                p = p - 32'h80000000;
            end
            x = GAIN_INV;
            y = 0;
            z = longint'($signed(p));
            for (int i = 0; i < 28; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= turn_tab[i];
                end
                else
                begin
                    x += dx; y -= dy; z += turn_tab[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        // Vectoring-mode CORDIC, angle of (p, q) in 2^-32 turn
        function logic [31:0] direction(longint q, longint p);
            longint z, dp, dq;
            z = 0;
            if (q == 0)
                return (p < 0) ? 32'h80000000 : 32'd0;
            if (p < 0)
            begin
                p = -p; q = -q; z = 64'sd2147483648;
            end
            for (int i = 0; i < 28; i++)
            begin
                dp = q >>> i;
                dq = p >>> i;
                if (q > 0)
                begin
                    p += dp; q -= dq; z += turn_tab[i];
                end
                else
                begin
                    p -= dp; q += dq; z -= turn_tab[i];
                end
            end
            return z[31:0];
        endfunction

        function void note_input(logic [15:0] sx, logic [15:0] sy);
            longint sa, ca, sb, cb, pp, qq;
            logic [32:0] rounded;
            sine_cosine(tilt_phase(sx), sa, ca);
            sine_cosine(tilt_phase(sy), sb, cb);
            pp = (sa * cb) >>> 30;
            qq = (ca * sb) >>> 30;
            rounded = {1'b0, direction(qq, pp)} + 33'h8000;
            expected_az.push_back(rounded[31:16]);
        endfunction

        function void check_result(logic [15:0] az);
            logic [15:0] want;
            checked++;
            if (expected_az.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result azimuth=%0d", az);
                return;
            end
            want = expected_az.pop_front();
            if (az !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("azimuth mismatch: expected %0d, got %0d (K=%0d)",
                             want, az, tilt_k);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] azimuth;

    azimuth_scoreboard sb;
    bit  idle_on;
    int  cycles;
    int  sent;

    stick_angle_on_sphere DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .stick_x   (stick_x),
        .stick_y   (stick_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .azimuth   (azimuth)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_stick_angle_on_sphere: errors");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_on && ($urandom_range(99) < 25);
    end

    // Note accepted items and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(stick_x, stick_y);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(azimuth);
    end

    task automatic send_item(input logic [15:0] sx, input logic [15:0] sy);
        // Hold valid low for random idle cycles
        while (idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        stick_x  <= sx;
        stick_y  <= sy;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_az.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_k(input logic [15:0] k);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.tilt_k = k;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            return 16'($urandom_range(65535));
        else if (sel == 3)
            return $urandom_range(1) ? 16'(FULL_DEFL) : 16'(-$signed(FULL_DEFL));
        else
            return 16'($signed($urandom_range(51200)) - 25600);
    endfunction

    logic [15:0] k_plan[6];

    initial
    begin
        sb = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'd0;
        in_valid  = 1'b0;
        stick_x   = '0;
        stick_y   = '0;
        out_stall = 1'b0;
        idle_on   = 1'b1;
        cycles    = 0;
        sent      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: origin, axes, full deflection, extremes, tiny values
        send_item(16'd0, 16'd0);
        send_item(FULL_DEFL, 16'd0);
        send_item(-FULL_DEFL, 16'd0);
        send_item(16'd0, FULL_DEFL);
        send_item(16'd0, -FULL_DEFL);
        send_item(FULL_DEFL, FULL_DEFL);
        send_item(-FULL_DEFL, FULL_DEFL);
        send_item(-FULL_DEFL, -FULL_DEFL);
        send_item(FULL_DEFL, -FULL_DEFL);
        send_item(16'h7FFF, 16'h7FFF);
        send_item(16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h8000, 16'h7FFF);
        send_item(16'h0001, 16'h0000);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'h0000, 16'hFFFF);
        send_item(16'h0001, 16'hFFFF);
        send_item(FULL_DEFL, 16'hFFFF);
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'hFFFF, 16'hFFFE);

        // Random phases across several tilt settings, one with no idling
        k_plan = '{K_RESET, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(65535)), 16'd25736};
        for (int p = 0; p < 6; p++)
        begin
            if (p != 0)
                write_k(k_plan[p]);
            idle_on = (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_coord(), rand_coord());
        end

        drain();
        sb.mismatches += sb.expected_az.size();
        $display("covered %0d stick items and %0d results over %0d tilt settings",
                 sent, sb.checked, 6);
        $display("settings included zero, full scale and reset tilt, with axis and edge inputs");
        if (sb.mismatches == 0)
            $display("tb_stick_angle_on_sphere: clean");
        else
            $display("tb_stick_angle_on_sphere: errors");
        $finish;
    end
endmodule
